// ===== src/msa_pkg.sv =====
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, codes and controller/datapath interface structs of the
// max-distance slot allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

  // built capacity of the row
  localparam int MAX_SLOTS = 256;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  // fixed field widths
  localparam int SLOT_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 9;
  localparam logic [CFG_W-1:0] ROOM_SIZE_RESET = CFG_W'(256);

  // command codes
  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch_in;    // capture the accepted word
    logic cnt_clear;   // reset the address counter
    logic cnt_inc;     // step the address counter
    logic clear_wr;    // write zero at the counter during the clearing pass
    logic scan_rd;     // read the bitmap at the counter
    logic rel_rd;      // read the bitmap at the captured slot
    logic commit;      // update state and load the output register
  } msa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // counter at the last slot of the built row
    logic scan_last;   // counter at the last slot of the active row
    logic count_zero;  // no slot taken anywhere
    logic out_free;    // output register can take a word this cycle
  } msa_stat_t;

endpackage

// ===== src/max_distance_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// max_distance_slot_allocator
// Hands out slots of a row so each new occupant sits as far as possible from
// the nearest taken slot; releases named slots.
// ----------------------------------------------------------------------------
// channel  direction  tdata               tuser
// in_      slave      slot_number [7:0]   command [0]
// out_     master     slot_result [7:0]   status [1:0]
// cfg_     write      room_size [8:0]     -
//
// allocate scans the bitmap memory one slot per cycle through its single
// read port over n slots, n being room_size clamped to 1..MAX_SLOTS; with
// no slot taken anywhere it skips the scan. release reads one bitmap bit.
// after reset a clearing pass over all MAX_SLOTS (256) slots zeroes the
// bitmap, in_tready stays low meanwhile; configuration writes are taken
// at any time. one word is worked on at a time; a word is accepted while
// the previous result waits, and a stalled result holds the block before
// its commit.
// ----------------------------------------------------------------------------
module max_distance_slot_allocator
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,    // room_size
  // command stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SLOT_W-1:0]   in_tdata,       // slot_number
  input  logic                in_tuser,       // command
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SLOT_W-1:0]   out_tdata,      // slot_result
  output logic [STATUS_W-1:0] out_tuser       // status
);

  msa_cmd_t  cmd;
  msa_stat_t stat;

  // sequencer
  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap and gap search
  msa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (in_tuser),
    .in_slot     (in_tdata),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_slot    (out_tdata),
    .out_status  (out_tuser),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== src/msa_ctrl.sv =====
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer for the clearing pass, the bitmap scan of an allocate and the
// lookup of a release.
// ----------------------------------------------------------------------------
module msa_ctrl
  import msa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  msa_stat_t stat,
  output msa_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_REL   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_TAIL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in  = 1'b1;
          cmd.cnt_clear = 1'b1;
          if (in_cmd == CMD_RELEASE) begin
            state_nxt = S_REL;
          end else if (stat.count_zero) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_REL: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/msa_dp.sv =====
// ----------------------------------------------------------------------------
// msa_dp
// Occupancy memory, gap tracker, room size register, occupant count and
// output register.
// ----------------------------------------------------------------------------
module msa_dp
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_cmd,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status,
  input  msa_cmd_t            cmd,
  output msa_stat_t           stat
);

  logic                mem [MAX_SLOTS];
  logic                rd_bit_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_data;

  logic [CFG_W-1:0]    room_size_r;
  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W-1:0]    count_r;

  logic                cmd_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [IDX_W-1:0]    cnt_r;

  logic                proc_en_r;
  logic [IDX_W-1:0]    proc_idx_r;
  logic                found_r;
  logic [IDX_W-1:0]    last_r;
  logic [IDX_W-1:0]    best_dist_r;
  logic [IDX_W-1:0]    best_seat_r;
  logic [IDX_W-1:0]    gap_half;

  logic [IDX_W-1:0]    tail_dist;
  logic [IDX_W-1:0]    seat;
  logic                row_full;
  logic                rel_ok;
  logic                alloc_ok;

  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;

  // room size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_size_r <= ROOM_SIZE_RESET;
    end else if (cfg_wr_en) begin
      room_size_r <= cfg_wr_data;
    end
  end

  // active row length, clamped to one..capacity
  always_comb begin
    if (room_size_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(room_size_r) > MAX_SLOTS) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(room_size_r);
    end
  end

  // captured word and address counter
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clear) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  // occupancy memory, one write and one registered read per cycle
  assign rd_addr = cmd.rel_rd ? IDX_W'(slot_r) : cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.rel_rd) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  // scan data arrives in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_en_r <= 1'b0;
    end else begin
      proc_en_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= cnt_r;
  end

  // widest-gap tracker
  assign gap_half = (proc_idx_r - last_r) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      found_r     <= 1'b0;
      last_r      <= '0;
      best_dist_r <= '0;
      best_seat_r <= '0;
    end else if (proc_en_r && rd_bit_r) begin
      last_r <= proc_idx_r;
      if (!found_r) begin
        found_r     <= 1'b1;
        best_dist_r <= proc_idx_r;
        best_seat_r <= '0;
      end else if (gap_half > best_dist_r) begin
        best_dist_r <= gap_half;
        best_seat_r <= last_r + gap_half;
      end
    end
  end

  // final pick including the right edge gap
  assign tail_dist = IDX_W'(n_eff - CNT_W'(1)) - last_r;

  always_comb begin
    if (!found_r) begin
      seat     = '0;
      row_full = 1'b0;
    end else if (tail_dist > best_dist_r) begin
      seat     = IDX_W'(n_eff - CNT_W'(1));
      row_full = 1'b0;
    end else begin
      seat     = best_seat_r;
      row_full = (best_dist_r == '0);
    end
  end

  assign alloc_ok = (cmd_r == CMD_ALLOCATE) && !row_full;
  assign rel_ok   = (cmd_r == CMD_RELEASE) && (CNT_W'(slot_r) < n_eff) && rd_bit_r;

  // memory write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = 1'b0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit && alloc_ok) begin
      wr_en   = 1'b1;
      wr_addr = seat;
      wr_data = 1'b1;
    end else if (cmd.commit && rel_ok) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(slot_r);
    end
  end

  // occupant count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit && alloc_ok) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.commit && rel_ok && (count_r != '0)) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd_r == CMD_RELEASE) begin
        out_slot_r   <= slot_r;
        out_status_r <= rel_ok ? STATUS_OK : STATUS_BAD_SLOT;
      end else begin
        out_slot_r   <= row_full ? '0 : SLOT_W'(seat);
        out_status_r <= row_full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;

  // status to the controller
  assign stat.clear_last = (cnt_r == IDX_W'(MAX_SLOTS - 1));
  assign stat.scan_last  = (cnt_r == IDX_W'(n_eff - CNT_W'(1)));
  assign stat.count_zero = (count_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ===== src/msa_checker.sv =====
// ----------------------------------------------------------------------------
// msa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module msa_checker
  import msa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [SLOT_W-1:0]   out_tdata,
  input logic [STATUS_W-1:0] out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // one word in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accept");

  // full row reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_FULL) |-> out_tdata == '0)
    else $error("full status with nonzero slot");

  // status uses defined codes only
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STATUS_OK) || (out_tuser == STATUS_FULL) ||
                   (out_tuser == STATUS_BAD_SLOT))
    else $error("undefined status code");

endmodule

bind max_distance_slot_allocator msa_checker u_msa_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_distance_slot_allocator. A short directed table
// covers the row edges, interior gaps, a full row, bad releases and row size
// changes; then random command phases run at varied row sizes. Every result
// word is compared with its table entry or with the bench's bitmap model.
// ----------------------------------------------------------------------------
module tb_top;
  import msa_pkg::*;

  localparam int RECV_HOLD    = 400;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_WORDS = 2000;

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } result_word_t;

  typedef struct {
    bit                is_cfg;
    bit                typed;
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [CFG_W-1:0]  size;
    result_word_t      want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [SLOT_W-1:0]   in_tdata;       // slot_number
  logic                in_tuser;       // command
  logic                out_tvalid;
  logic                out_tready;
  logic [SLOT_W-1:0]   out_tdata;      // slot_result
  logic [STATUS_W-1:0] out_tuser;      // status

  // bench copy of the allocator state
  bit               seat_taken [MAX_SLOTS];
  int unsigned      taken_count;
  logic [CFG_W-1:0] room_size_q;

  result_word_t awaited_results[$];
  plan_row_t    plan[$];
  int           errors       = 0;
  int           results_seen = 0;
  bit           calm         = 1'b0;

  max_distance_slot_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // row size as the allocator sees it, clamped to 1..MAX_SLOTS
  function automatic int active_size();
    if (room_size_q == 0) return 1;
    if (room_size_q > MAX_SLOTS) return MAX_SLOTS;
    return int'(room_size_q);
  endfunction

  // widest gap search over slots below n; -1 when nothing is free
  function automatic int farthest_free(input int n);
    int first_taken;
    int last_taken;
    int best_gap;
    int best_slot;
    int gap;
    first_taken = -1;
    last_taken  = -1;
    best_gap    = 0;
    best_slot   = 0;
    for (int i = 0; i < n; i++) begin
      if (seat_taken[i]) begin
        if (last_taken < 0) begin
          first_taken = i;
          best_gap    = i;
          best_slot   = 0;
        end else begin
          gap = (i - last_taken) / 2;
          if (gap > best_gap) begin
            best_gap  = gap;
            best_slot = last_taken + gap;
          end
        end
        last_taken = i;
      end
    end
    if (first_taken < 0) return 0;
    if (n - 1 - last_taken > best_gap) begin
      best_gap  = n - 1 - last_taken;
      best_slot = n - 1;
    end
    if (best_gap == 0) return -1;
    return best_slot;
  endfunction

  // apply one command word to the bench state and give its result word
  task automatic allocator_step(input logic cmd, input logic [SLOT_W-1:0] slot,
                                output result_word_t res);
    int n;
    int seat;
    n = active_size();
    if (cmd == CMD_ALLOCATE) begin
      seat = farthest_free(n);
      if (seat < 0) begin
        res.slot   = '0;
        res.status = STATUS_FULL;
      end else begin
        seat_taken[seat] = 1'b1;
        taken_count++;
        res.slot   = SLOT_W'(seat);
        res.status = STATUS_OK;
      end
    end else begin
      res.slot = slot;
      if (int'(slot) >= n || !seat_taken[slot]) begin
        res.status = STATUS_BAD_SLOT;
      end else begin
        seat_taken[slot] = 1'b0;
        if (taken_count > 0) taken_count--;
        res.status = STATUS_OK;
      end
    end
  endtask

  // offer one command word after a random gap, log its result once taken
  task automatic offer_word(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input bit typed, input result_word_t want);
    int gap;
    result_word_t res;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= slot;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    allocator_step(cmd, slot, res);
    awaited_results.push_back(typed ? want : res);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_room(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    room_size_q = value;
  endtask

  // plan builders for the directed table
  task automatic row_word(input logic cmd, input logic [SLOT_W-1:0] slot);
    plan_row_t r;
    r = '{default: '0};
    r.cmd  = cmd;
    r.slot = slot;
    plan.push_back(r);
  endtask

  task automatic row_want(input logic cmd, input logic [SLOT_W-1:0] slot,
                          input logic [SLOT_W-1:0] want_slot,
                          input logic [STATUS_W-1:0] want_status);
    plan_row_t r;
    r = '{default: '0};
    r.typed       = 1'b1;
    r.cmd         = cmd;
    r.slot        = slot;
    r.want.slot   = want_slot;
    r.want.status = want_status;
    plan.push_back(r);
  endtask

  task automatic row_room(input logic [CFG_W-1:0] size);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.size   = size;
    plan.push_back(r);
  endtask

  // result side: random back-pressure, a few long hold-offs, field checks
  initial begin : result_sink
    int gap;
    result_word_t head;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == 600 || results_seen == 1100 || results_seen == 1600)
        gap = RECV_HOLD;
      else
        gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word slot %0d status %0d",
                                out_tdata, out_tuser));
      end else begin
        head = awaited_results.pop_front();
        if (out_tdata !== head.slot)
          flag_mismatch($sformatf("word %0d slot_result %0d, wanted %0d",
                                  results_seen, out_tdata, head.slot));
        if (out_tuser !== head.status)
          flag_mismatch($sformatf("word %0d status %0d, wanted %0d",
                                  results_seen, out_tuser, head.status));
      end
    end
  end

  // command side: directed table, then random phases
  initial begin : command_source
    plan_row_t    row;
    result_word_t none;
    int           sent;
    int           phase_len;
    int           alloc_pct;
    int           taken_list[$];
    logic         cmd;
    logic [SLOT_W-1:0] slot;
    logic [CFG_W-1:0]  size;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_ALLOCATE;
    out_tready  = 1'b0;
    none        = '{default: '0};
    sent        = 0;
    room_size_q = ROOM_SIZE_RESET;
    taken_count = 0;
    foreach (seat_taken[i]) seat_taken[i] = 1'b0;

    // full row at reset size: empty row, right edge, interior gap
    row_want(CMD_ALLOCATE, 8'hFF, 8'd0,   STATUS_OK);
    row_want(CMD_ALLOCATE, 8'h00, 8'd255, STATUS_OK);
    row_word(CMD_ALLOCATE, 8'h5A);
    row_want(CMD_RELEASE,  8'd255, 8'd255, STATUS_OK);
    row_want(CMD_RELEASE,  8'd255, 8'd255, STATUS_BAD_SLOT);
    row_word(CMD_ALLOCATE, 8'hA5);
    // size zero acts as one slot, which is already taken
    row_room(9'd0);
    row_want(CMD_ALLOCATE, 8'h00, 8'd0, STATUS_FULL);
    row_want(CMD_RELEASE,  8'd1,  8'd1, STATUS_BAD_SLOT);
    row_want(CMD_RELEASE,  8'd0,  8'd0, STATUS_OK);
    row_want(CMD_ALLOCATE, 8'hFF, 8'd0, STATUS_OK);
    // two slots, shrunk row with taken slots beyond it
    row_room(9'd2);
    row_word(CMD_ALLOCATE, 8'h33);
    row_want(CMD_ALLOCATE, 8'hCC, 8'd0, STATUS_FULL);
    row_want(CMD_RELEASE,  8'd127, 8'd127, STATUS_BAD_SLOT);
    row_word(CMD_RELEASE,  8'd1);
    // above the built capacity acts as the full row
    row_room(9'd511);
    row_want(CMD_RELEASE,  8'd127, 8'd127, STATUS_OK);
    row_want(CMD_RELEASE,  8'd255, 8'd255, STATUS_OK);
    row_want(CMD_RELEASE,  8'd200, 8'd200, STATUS_BAD_SLOT);
    // three slots: right edge, interior, then full
    row_room(9'd3);
    row_word(CMD_ALLOCATE, 8'h0F);
    row_word(CMD_ALLOCATE, 8'hF0);
    row_want(CMD_ALLOCATE, 8'h81, 8'd0, STATUS_FULL);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        drain_results();
        write_room(row.size);
      end else begin
        offer_word(row.cmd, row.slot, row.typed, row.want);
      end
    end

    // random phases, each at its own row size, drained before the next
    while (sent < RANDOM_WORDS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0:       size = 9'd0;
        1:       size = 9'd1;
        2:       size = 9'd2;
        3:       size = 9'd256;
        4:       size = 9'd511;
        5:       size = CFG_W'($urandom_range(257, 510));
        6:       size = CFG_W'($urandom_range(41, 255));
        default: size = CFG_W'($urandom_range(3, 40));
      endcase
      write_room(size);
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 25;
        1:       alloc_pct = 55;
        default: alloc_pct = 85;
      endcase
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        slot = SLOT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < alloc_pct) begin
          cmd = CMD_ALLOCATE;
        end else begin
          cmd = CMD_RELEASE;
          // mostly free a slot that is really taken, otherwise noise
          if ($urandom_range(0, 9) < 8) begin
            taken_list.delete();
            for (int i = 0; i < active_size(); i++)
              if (seat_taken[i]) taken_list.push_back(i);
            if (taken_list.size() != 0)
              slot = SLOT_W'(taken_list[$urandom_range(0, taken_list.size() - 1)]);
          end
        end
        offer_word(cmd, slot, 1'b0, none);
        sent++;
      end
    end

    drain_results();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/msa_pkg.sv
src/msa_ctrl.sv
src/msa_dp.sv
src/max_distance_slot_allocator.sv
src/msa_checker.sv
sim/tb_top.sv
